// ===== rtl/epm_pkg.sv =====
// Shared types, constants and codes for the expect pattern matcher.
package epm_pkg;

    localparam int WINDOW_DEPTH    = 64;
    localparam int MAX_TRANSITIONS = 8;
    localparam int MAX_PATTERN_LEN = 16;

    localparam int WIN_AW = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int MT_IW  = $clog2(MAX_TRANSITIONS);
    localparam int MT_CW  = $clog2(MAX_TRANSITIONS + 1);
    localparam int PL_IW  = $clog2(MAX_PATTERN_LEN);
    localparam int PL_CW  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int PAT_AW = MT_IW + PL_IW;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_STAR = 8'h2a;
    localparam logic [7:0] CH_DOT  = 8'h2e;
    localparam logic [7:0] CH_BSL  = 8'h5c;
    localparam logic [7:0] CH_MASK = 8'h7f;

    localparam logic [2:0] CMD_CHAR    = 3'd0;
    localparam logic [2:0] CMD_TIMEOUT = 3'd1;
    localparam logic [2:0] CMD_WRITE   = 3'd2;
    localparam logic [2:0] CMD_LEN     = 3'd3;
    localparam logic [2:0] CMD_SCAN    = 3'd4;

    localparam logic [2:0] EV_WAIT     = 3'd0;
    localparam logic [2:0] EV_MATCH    = 3'd1;
    localparam logic [2:0] EV_TIMEOUT  = 3'd2;
    localparam logic [2:0] EV_EXIT     = 3'd3;
    localparam logic [2:0] EV_OVERFLOW = 3'd4;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_TIMEOUT,
        OP_WRITE,
        OP_LEN,
        OP_SCAN,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [2:0] idx;
        logic [3:0] pos;
        logic [4:0] plen;
    } item_t;

    typedef enum logic [1:0] {
        TR_FULL,
        TR_PART,
        TR_NONE
    } try_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_PAT,
        S_RD,
        S_CMP,
        S_REC,
        S_DECIDE,
        S_EMIT
    } state_t;

endpackage

// ===== rtl/epm_front.sv =====
// Front end: accepts items, decodes the command and queues them for the back end.
module epm_front
    import epm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] cmd,
    input  logic [7:0] data_byte,
    input  logic [2:0] pattern_index,
    input  logic [3:0] pattern_pos,
    input  logic [4:0] pattern_len,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    item_t      fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      dec_item;
    logic       push;
    logic       pop;

    always_comb
    begin
        dec_item.data = data_byte;
        dec_item.idx  = pattern_index;
        dec_item.pos  = pattern_pos;
        dec_item.plen = pattern_len;
        unique case (cmd)
            CMD_CHAR:    dec_item.op = OP_CHAR;
            CMD_TIMEOUT: dec_item.op = OP_TIMEOUT;
            CMD_WRITE:   dec_item.op = OP_WRITE;
            CMD_LEN:     dec_item.op = OP_LEN;
            CMD_SCAN:    dec_item.op = OP_SCAN;
            default:     dec_item.op = OP_NOP;
        endcase
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= dec_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/epm_back.sv =====
// Back end: window and pattern memories, match sequencer and result register.
module epm_back
    import epm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_res,
    output logic [2:0] transition_index,
    output logic [6:0] match_length
);

    // memories
    logic [6:0] win_mem [WINDOW_DEPTH];
    logic [7:0] pat_mem [MAX_TRANSITIONS * MAX_PATTERN_LEN];
    logic [6:0] win_rdata_reg;
    logic [7:0] pat_rdata_reg;
    logic              win_we;
    logic [WIN_AW-1:0] win_waddr, win_raddr;
    logic              pat_we;
    logic [PAT_AW-1:0] pat_waddr, pat_raddr;

    logic [7:0]       first_reg [MAX_TRANSITIONS];
    logic [PL_CW-1:0] len_reg [MAX_TRANSITIONS];
    logic             len_we;
    logic [PL_CW-1:0] len_wval;

    logic [MAX_TRANSITIONS-1:0] lone_hash, lone_star;

    state_t            state_reg, state_next;
    logic [3:0]        tc_reg;
    logic [WIN_AW-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [MT_CW-1:0]  k_reg, k_next;
    logic [PL_CW-1:0]  ti_reg, ti_next;
    logic [FILL_W-1:0] si_reg, si_next;
    logic [FILL_W-1:0] off_reg, off_next;
    logic [7:0]        prev_reg, prev_next;
    try_res_t          tres_reg, tres_next;
    logic              full_v_reg, full_v_next;
    logic [MT_IW-1:0]  full_idx_reg, full_idx_next;
    logic              part_v_reg, part_v_next;
    logic [FILL_W-1:0] mlen_reg, mlen_next;
    logic              star_reg, star_next;
    logic [2:0]        rev_reg, rev_next;
    logic [2:0]        ridx_reg, ridx_next;
    logic [FILL_W-1:0] rlen_reg, rlen_next;
    logic              ov_reg, ov_next;
    logic [2:0]        oev_reg, oev_next;
    logic [2:0]        oidx_reg, oidx_next;
    logic [6:0]        olen_reg, olen_next;

    logic [MT_CW-1:0]  n_act;
    logic [MT_IW-1:0]  k_i;
    logic              hash_found;
    logic [MT_IW-1:0]  hash_idx;
    logic [7:0]        c;
    logic              last_bsl;

    assign n_act = (tc_reg > MAX_TRANSITIONS) ? MT_CW'(MAX_TRANSITIONS) : MT_CW'(tc_reg);
    assign k_i   = k_reg[MT_IW-1:0];
    assign c     = pat_rdata_reg;
    assign last_bsl = (ti_reg != '0) && (prev_reg == CH_BSL);

    always_comb
    begin
        for (int i = 0; i < MAX_TRANSITIONS; i++)
        begin
            lone_hash[i] = (len_reg[i] == PL_CW'(1)) && (first_reg[i] == CH_HASH);
            lone_star[i] = (len_reg[i] == PL_CW'(1)) && (first_reg[i] == CH_STAR);
        end
    end

    // first active lone '#'
    always_comb
    begin
        hash_found = 1'b0;
        hash_idx   = '0;
        for (int i = MAX_TRANSITIONS - 1; i >= 0; i--)
        begin
            if (lone_hash[i] && (MT_CW'(i) < n_act))
            begin
                hash_found = 1'b1;
                hash_idx   = MT_IW'(i);
            end
        end
    end

    assign win_waddr = head_reg + fill_reg[WIN_AW-1:0];
    assign win_raddr = head_reg + si_reg[WIN_AW-1:0];
    assign win_we    = (state_reg == S_IDLE) && q_valid && (q_item.op == OP_CHAR)
                       && (fill_reg < FILL_W'(WINDOW_DEPTH));
    assign pat_waddr = {q_item.idx[MT_IW-1:0], q_item.pos[PL_IW-1:0]};
    assign pat_raddr = {k_i, ti_reg[PL_IW-1:0]};
    assign pat_we    = (state_reg == S_IDLE) && q_valid && (q_item.op == OP_WRITE)
                       && ({1'b0, q_item.idx} < 4'(MAX_TRANSITIONS))
                       && ({1'b0, q_item.pos} < 5'(MAX_PATTERN_LEN));
    assign len_we    = (state_reg == S_IDLE) && q_valid && (q_item.op == OP_LEN)
                       && ({1'b0, q_item.idx} < 4'(MAX_TRANSITIONS));
    assign len_wval  = (q_item.plen > 5'(MAX_PATTERN_LEN)) ? PL_CW'(MAX_PATTERN_LEN)
                                                           : PL_CW'(q_item.plen);

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[win_waddr] <= q_item.data[6:0] & CH_MASK[6:0];
        end
        win_rdata_reg <= win_mem[win_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pat_waddr] <= q_item.data;
        end
        pat_rdata_reg <= pat_mem[pat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pat_we && (q_item.pos == 4'd0))
        begin
            first_reg[q_item.idx[MT_IW-1:0]] <= q_item.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TRANSITIONS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (len_we)
        begin
            len_reg[q_item.idx[MT_IW-1:0]] <= len_wval;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        k_next        = k_reg;
        ti_next       = ti_reg;
        si_next       = si_reg;
        off_next      = off_reg;
        prev_next     = prev_reg;
        tres_next     = tres_reg;
        full_v_next   = full_v_reg;
        full_idx_next = full_idx_reg;
        part_v_next   = part_v_reg;
        mlen_next     = mlen_reg;
        star_next     = star_reg;
        rev_next      = rev_reg;
        ridx_next     = ridx_reg;
        rlen_next     = rlen_reg;
        q_pop         = 1'b0;
        ov_next       = ov_reg && out_stall;
        oev_next      = oev_reg;
        oidx_next     = oidx_reg;
        olen_next     = olen_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    rev_next   = EV_WAIT;
                    ridx_next  = '0;
                    rlen_next  = '0;
                    state_next = S_EMIT;
                    unique case (q_item.op)
                        OP_CHAR:
                        begin
                            if (fill_reg >= FILL_W'(WINDOW_DEPTH))
                            begin
                                rev_next = EV_OVERFLOW;
                            end
                            else
                            begin
                                fill_next  = fill_reg + FILL_W'(1);
                                state_next = S_SCAN;
                            end
                        end
                        OP_TIMEOUT:
                        begin
                            fill_next = '0;
                            if (hash_found)
                            begin
                                rev_next  = EV_TIMEOUT;
                                ridx_next = 3'(hash_idx);
                            end
                            else
                            begin
                                rev_next = EV_EXIT;
                            end
                        end
                        OP_SCAN:    state_next = S_SCAN;
                        OP_WRITE,
                        OP_LEN,
                        OP_NOP:     state_next = S_EMIT;
                        default:    state_next = S_EMIT;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (fill_reg == '0)
                begin
                    rev_next   = EV_WAIT;
                    ridx_next  = '0;
                    rlen_next  = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    k_next      = '0;
                    off_next    = '0;
                    full_v_next = 1'b0;
                    part_v_next = 1'b0;
                    star_next   = 1'b0;
                    state_next  = S_PAT;
                end
            end
            S_PAT:
            begin
                if (star_reg && (off_reg == fill_reg))
                begin
                    head_next  = head_reg + fill_reg[WIN_AW-1:0];
                    fill_next  = '0;
                    rev_next   = EV_MATCH;
                    ridx_next  = 3'(full_idx_reg);
                    rlen_next  = fill_reg;
                    state_next = S_EMIT;
                end
                else if (k_reg == n_act)
                begin
                    if (star_reg)
                    begin
                        off_next = off_reg + FILL_W'(1);
                        k_next   = '0;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
                else if (lone_hash[k_i] || (star_reg && lone_star[k_i]))
                begin
                    k_next = k_reg + MT_CW'(1);
                end
                else if (lone_star[k_i])
                begin
                    tres_next  = TR_FULL;
                    si_next    = off_reg;
                    state_next = S_REC;
                end
                else
                begin
                    ti_next    = '0;
                    si_next    = off_reg;
                    prev_next  = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (ti_reg == len_reg[k_i])
                begin
                    tres_next  = TR_FULL;
                    state_next = S_REC;
                end
                else if (si_reg >= fill_reg)
                begin
                    tres_next  = TR_PART;
                    state_next = S_REC;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                prev_next  = c;
                ti_next    = ti_reg + PL_CW'(1);
                state_next = S_RD;
                if (c != CH_BSL)
                begin
                    if (({1'b0, win_rdata_reg} != c) && ((c != CH_DOT) || last_bsl))
                    begin
                        tres_next  = TR_NONE;
                        state_next = S_REC;
                    end
                    else
                    begin
                        si_next = si_reg + FILL_W'(1);
                    end
                end
            end
            S_REC:
            begin
                k_next     = k_reg + MT_CW'(1);
                state_next = S_PAT;
                if (star_reg)
                begin
                    if (tres_reg != TR_NONE)
                    begin
                        head_next  = head_reg + off_reg[WIN_AW-1:0];
                        fill_next  = fill_reg - off_reg;
                        rev_next   = EV_MATCH;
                        ridx_next  = 3'(full_idx_reg);
                        rlen_next  = off_reg;
                        state_next = S_EMIT;
                    end
                end
                else if ((tres_reg == TR_FULL) && !full_v_reg)
                begin
                    full_v_next   = 1'b1;
                    full_idx_next = k_i;
                    mlen_next     = si_reg - off_reg;
                end
                else if ((tres_reg == TR_PART) && !part_v_reg)
                begin
                    part_v_next = 1'b1;
                end
            end
            S_DECIDE:
            begin
                if (!full_v_reg && !part_v_reg)
                begin
                    head_next  = head_reg + WIN_AW'(1);
                    fill_next  = fill_reg - FILL_W'(1);
                    state_next = S_SCAN;
                end
                else if (full_v_reg && !part_v_reg)
                begin
                    if (lone_star[full_idx_reg])
                    begin
                        star_next  = 1'b1;
                        off_next   = '0;
                        k_next     = '0;
                        state_next = S_PAT;
                    end
                    else
                    begin
                        head_next  = head_reg + mlen_reg[WIN_AW-1:0];
                        fill_next  = fill_reg - mlen_reg;
                        rev_next   = EV_MATCH;
                        ridx_next  = 3'(full_idx_reg);
                        rlen_next  = mlen_reg;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    rev_next   = EV_WAIT;
                    ridx_next  = '0;
                    rlen_next  = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    oev_next   = rev_reg;
                    oidx_next  = ridx_reg;
                    olen_next  = 7'(rlen_reg);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        ti_reg       <= ti_next;
        si_reg       <= si_next;
        off_reg      <= off_next;
        prev_reg     <= prev_next;
        tres_reg     <= tres_next;
        full_v_reg   <= full_v_next;
        full_idx_reg <= full_idx_next;
        part_v_reg   <= part_v_next;
        mlen_reg     <= mlen_next;
        star_reg     <= star_next;
        rev_reg      <= rev_next;
        ridx_reg     <= ridx_next;
        rlen_reg     <= rlen_next;
        oev_reg      <= oev_next;
        oidx_reg     <= oidx_next;
        olen_reg     <= olen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            ov_reg    <= 1'b0;
            tc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            ov_reg    <= ov_next;
            if (cfg_wr_en)
            begin
                tc_reg <= cfg_wr_data;
            end
        end
    end

    assign out_valid        = ov_reg;
    assign event_res        = oev_reg;
    assign transition_index = oidx_reg;
    assign match_length     = olen_reg;

endmodule

// ===== rtl/expect_pattern_matcher.sv =====
// Top level of the expect pattern matcher: front queue plus match sequencer.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------------
//  in       | in_valid / in_stall  | cmd, data_byte, pattern_index, pattern_pos, pattern_len
//  out      | out_valid / out_stall| event_res, transition_index, match_length
//  cfg      | cfg_wr_en            | cfg_wr_data (transition_count)
//
// Pattern writes, length writes, timeouts and unused commands go from idle to emit.
// A character or rescan walks each active pattern byte by byte, via a read and a
// compare state (the registered read of the window and pattern memories), and repeats
// the walk on every one-byte window shift; a lone '*' adds a walk per window offset.
// Reset clears the window fill, pattern lengths and transition count; no clearing pass.
// A two-entry queue accepts transfers until full while the result register is stalled.
module expect_pattern_matcher
    import epm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] cmd,
    input  logic [7:0] data_byte,
    input  logic [2:0] pattern_index,
    input  logic [3:0] pattern_pos,
    input  logic [4:0] pattern_len,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_res,
    output logic [2:0] transition_index,
    output logic [6:0] match_length
);

    // decoded items between front and back
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    epm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .data_byte     (data_byte),
        .pattern_index (pattern_index),
        .pattern_pos   (pattern_pos),
        .pattern_len   (pattern_len),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // match sequencer owns the window, pattern table and result register
    epm_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_res        (event_res),
        .transition_index (transition_index),
        .match_length     (match_length)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the expect pattern matcher.
module tb_top;
    import epm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] ev;
        logic [2:0] tidx;
        logic [6:0] mlen;
    } result_t;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] data;
        logic [2:0] idx;
        logic [3:0] pos;
        logic [4:0] plen;
        bit         typed;  // expected result written in the table
        result_t    res;
    } stim_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [3:0] cfg_wr_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] cmd = '0;
    logic [7:0] data_byte = '0;
    logic [2:0] pattern_index = '0;
    logic [3:0] pattern_pos = '0;
    logic [4:0] pattern_len = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] event_res;
    logic [2:0] transition_index;
    logic [6:0] match_length;

    expect_pattern_matcher DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .data_byte        (data_byte),
        .pattern_index    (pattern_index),
        .pattern_pos      (pattern_pos),
        .pattern_len      (pattern_len),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_res        (event_res),
        .transition_index (transition_index),
        .match_length     (match_length)
    );

    always #5 clk = ~clk;

    // Matcher state as the testbench sees it
    logic [6:0] win_buf [WINDOW_DEPTH];
    int         win_fill;
    logic [7:0] pat_mem [MAX_TRANSITIONS][MAX_PATTERN_LEN];
    bit         pat_written [MAX_TRANSITIONS][MAX_PATTERN_LEN];
    int         pat_len [MAX_TRANSITIONS];
    int         trans_cnt;

    result_t    pending_results [$];
    int         fail_cnt = 0;
    int         gap_pct = 0;     // chance of a gap after each input transfer
    int         stall_pct = 0;   // chance of a receiver stall each cycle
    int         hold_cycles = 0; // long receiver hold, counted in the receiver

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------
    function automatic int active_slots();
        return (trans_cnt > MAX_TRANSITIONS) ? MAX_TRANSITIONS : trans_cnt;
    endfunction

    function automatic bit is_single(int k, logic [7:0] ch);
        return pat_len[k] == 1 && pat_mem[k][0] == ch;
    endfunction

    // Walk pattern k against the window from offset off
    function automatic try_res_t walk_pattern(int off, int k, output int len);
        int si;
        logic [7:0] c;
        si = off;
        len = 0;
        if (is_single(k, CH_STAR))
            return TR_FULL;
        for (int ti = 0; ti < pat_len[k]; ti++) begin
            if (si >= win_fill)
                return TR_PART;
            c = pat_mem[k][ti];
            if (c != CH_BSL) begin
                // escaped dot is literal, a bare dot is a wildcard
                if ({1'b0, win_buf[si]} != c &&
                    (c != CH_DOT || (ti > 0 && pat_mem[k][ti-1] == CH_BSL)))
                    return TR_NONE;
                si++;
            end
        end
        len = si - off;
        return TR_FULL;
    endfunction

    // A lone star eats up to where some ordinary pattern could start
    function automatic int star_span();
        int dummy;
        for (int off = 0; off < win_fill; off++)
            for (int k = 0; k < active_slots(); k++) begin
                if (is_single(k, CH_HASH) || is_single(k, CH_STAR))
                    continue;
                if (walk_pattern(off, k, dummy) != TR_NONE)
                    return off;
            end
        return win_fill;
    endfunction

    function automatic void drop_window(int n);
        if (n > win_fill)
            n = win_fill;
        for (int i = 0; i + n < win_fill; i++)
            win_buf[i] = win_buf[i + n];
        win_fill -= n;
    endfunction

    function automatic result_t scan_window();
        result_t r;
        int full, part, l, mlen;
        try_res_t t;
        r = '0;
        while (win_fill != 0) begin
            full = -1;
            part = -1;
            mlen = 0;
            for (int k = 0; k < active_slots(); k++) begin
                if (is_single(k, CH_HASH))
                    continue;
                t = walk_pattern(0, k, l);
                if (t == TR_FULL && full < 0) begin
                    full = k;
                    mlen = l;
                end else if (t == TR_PART && part < 0) begin
                    part = k;
                end
            end
            if (full < 0 && part < 0) begin
                drop_window(1);
                continue;
            end
            if (full >= 0 && part < 0) begin
                if (is_single(full, CH_STAR))
                    mlen = star_span();
                drop_window(mlen);
                r.ev = EV_MATCH;
                r.tidx = 3'(full);
                r.mlen = 7'(mlen);
            end
            return r;  // partial match waits for more characters
        end
        return r;
    endfunction

    function automatic result_t predict_result(stim_t s);
        result_t r;
        r = '0;
        case (s.cmd)
            CMD_CHAR:
                if (win_fill >= WINDOW_DEPTH) begin
                    r.ev = EV_OVERFLOW;
                end else begin
                    win_buf[win_fill] = s.data[6:0];
                    win_fill++;
                    r = scan_window();
                end
            CMD_TIMEOUT: begin
                win_fill = 0;
                r.ev = EV_EXIT;
                for (int k = 0; k < active_slots(); k++)
                    if (is_single(k, CH_HASH)) begin
                        r.ev = EV_TIMEOUT;
                        r.tidx = 3'(k);
                        break;
                    end
            end
            CMD_WRITE: begin
                pat_mem[s.idx][s.pos] = s.data;
                pat_written[s.idx][s.pos] = 1'b1;
            end
            CMD_LEN:
                pat_len[s.idx] = (s.plen > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : s.plen;
            CMD_SCAN:
                r = scan_window();
            default: ;
        endcase
        return r;
    endfunction

    //------------------------------------------------------------------
    // Driving
    //------------------------------------------------------------------
    function automatic stim_t mk(logic [2:0] c, logic [7:0] d, logic [2:0] i,
                                 logic [3:0] p, logic [4:0] l);
        stim_t s;
        s.cmd = c;
        s.data = d;
        s.idx = i;
        s.pos = p;
        s.plen = l;
        s.typed = 1'b0;
        s.res = '0;
        return s;
    endfunction

    function automatic stim_t mk_typed(stim_t s, logic [2:0] ev, logic [2:0] ti,
                                       logic [6:0] ml);
        s.typed = 1'b1;
        s.res = '{ev: ev, tidx: ti, mlen: ml};
        return s;
    endfunction

    // Offer one input transfer and wait until it is taken
    task automatic send(stim_t s);
        result_t r;
        int gap;
        in_valid <= 1'b1;
        cmd <= s.cmd;
        data_byte <= s.data;
        pattern_index <= s.idx;
        pattern_pos <= s.pos;
        pattern_len <= s.plen;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = predict_result(s);
        pending_results.push_back(s.typed ? s.res : r);
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Let every pending result come back, then leave the block idle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_count(logic [3:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        trans_cnt = v;
    endtask

    function automatic logic [7:0] pick_pat_byte();
        logic [7:0] set [7];
        set = '{8'h61, 8'h62, 8'h63, CH_DOT, CH_BSL, CH_STAR, CH_HASH};
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return set[$urandom_range(0, 6)];
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return 8'($urandom_range(8'h61, 8'h63));
        if (r < 90)
            return CH_DOT;
        return 8'($urandom_range(0, 255));
    endfunction

    // Program slot k: its bytes first, then the length
    task automatic program_slot(int k);
        int l, r;
        logic [4:0] lenv;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            send(mk(CMD_WRITE, ($urandom_range(0, 1) ? CH_STAR : CH_HASH), 3'(k), '0, '0));
            l = 1;
        end else begin
            l = (r < 25) ? MAX_PATTERN_LEN : $urandom_range(0, 4);
            for (int p = 0; p < l; p++)
                send(mk(CMD_WRITE, pick_pat_byte(), 3'(k), 4'(p), '0));
        end
        lenv = (l == MAX_PATTERN_LEN) ? 5'($urandom_range(MAX_PATTERN_LEN, 31)) : 5'(l);
        send(mk(CMD_LEN, '0, 3'(k), '0, lenv));
    endtask

    // Largest length that reads only written pattern bytes
    function automatic int written_prefix(int k);
        int w;
        w = 0;
        while (w < MAX_PATTERN_LEN && pat_written[k][w])
            w++;
        return w;
    endfunction

    task automatic random_item();
        int r, k, w;
        logic [4:0] lv;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, MAX_TRANSITIONS - 1);
        if (r < 70) begin
            send(mk(CMD_CHAR, pick_char(), 3'($urandom), 4'($urandom), 5'($urandom)));
        end else if (r < 77) begin
            send(mk(CMD_WRITE, 8'($urandom), 3'(k), 4'($urandom), 5'($urandom)));
        end else if (r < 82) begin
            w = written_prefix(k);
            lv = 5'($urandom_range(0, w));
            if (w == MAX_PATTERN_LEN && lv == MAX_PATTERN_LEN)
                lv = 5'($urandom_range(MAX_PATTERN_LEN, 31));
            send(mk(CMD_LEN, 8'($urandom), 3'(k), 4'($urandom), lv));
        end else if (r < 88) begin
            send(mk(CMD_TIMEOUT, 8'($urandom), 3'($urandom), 4'($urandom), 5'($urandom)));
        end else if (r < 95) begin
            send(mk(CMD_SCAN, 8'($urandom), 3'($urandom), 4'($urandom), 5'($urandom)));
        end else begin
            send(mk(3'(OP_NOP) + 3'($urandom_range(0, 2)), 8'($urandom), 3'($urandom),
                    4'($urandom), 5'($urandom)));
        end
    endtask

    //------------------------------------------------------------------
    // Receiver: random stalls, one long hold on request, and the checker
    //------------------------------------------------------------------
    always @(posedge clk) begin
        result_t want;
        if (out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: event_res %0d", event_res);
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (event_res !== want.ev) begin
                    $error("event_res: expected %0d, actual %0d", want.ev, event_res);
                    fail_cnt++;
                end
                if (transition_index !== want.tidx) begin
                    $error("transition_index: expected %0d, actual %0d",
                           want.tidx, transition_index);
                    fail_cnt++;
                end
                if (match_length !== want.mlen) begin
                    $error("match_length: expected %0d, actual %0d", want.mlen, match_length);
                    fail_cnt++;
                end
            end
        end
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles--;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------
    initial begin
        stim_t dir_tab [$];
        logic [3:0] counts [8];
        counts = '{4'd15, 4'd0, 4'd8, 4'd3, 4'd1, 4'd8, 4'd5, 4'd2};
        win_fill = 0;
        trans_cnt = 0;
        for (int k = 0; k < MAX_TRANSITIONS; k++) begin
            pat_len[k] = 0;
            for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
                pat_mem[k][p] = '0;
                pat_written[k][p] = 1'b0;
            end
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: count above the maximum, so all eight slots are active
        write_count(4'd15);
        // every slot starts with length zero, so slot 0 matches with length 0
        dir_tab.push_back(mk_typed(mk(CMD_CHAR, 8'hff, 3'd0, 4'd0, 5'd0), EV_MATCH, 0, 0));
        dir_tab.push_back(mk_typed(mk(CMD_TIMEOUT, 8'h00, 3'd7, 4'd15, 5'd31), EV_EXIT, 0, 0));
        dir_tab.push_back(mk_typed(mk(CMD_SCAN, 8'h00, 3'd0, 4'd0, 5'd0), EV_WAIT, 0, 0));
        for (int u = 0; u < 3; u++)
            dir_tab.push_back(mk_typed(mk(3'(OP_NOP) + 3'(u), 8'hff, 3'd7, 4'd15, 5'd31),
                                       EV_WAIT, 0, 0));
        // slot 0: "a\.." (a, literal dot, any char)
        dir_tab.push_back(mk_typed(mk(CMD_WRITE, 8'h61, 3'd0, 4'd0, 5'd0), EV_WAIT, 0, 0));
        dir_tab.push_back(mk_typed(mk(CMD_WRITE, CH_BSL, 3'd0, 4'd1, 5'd0), EV_WAIT, 0, 0));
        dir_tab.push_back(mk_typed(mk(CMD_WRITE, CH_DOT, 3'd0, 4'd2, 5'd0), EV_WAIT, 0, 0));
        dir_tab.push_back(mk_typed(mk(CMD_WRITE, CH_DOT, 3'd0, 4'd3, 5'd0), EV_WAIT, 0, 0));
        dir_tab.push_back(mk_typed(mk(CMD_LEN, 8'h00, 3'd0, 4'd0, 5'd4), EV_WAIT, 0, 0));
        // slot 1 lone hash, slot 2 lone star
        dir_tab.push_back(mk_typed(mk(CMD_WRITE, CH_HASH, 3'd1, 4'd0, 5'd0), EV_WAIT, 0, 0));
        dir_tab.push_back(mk_typed(mk(CMD_LEN, 8'h00, 3'd1, 4'd0, 5'd1), EV_WAIT, 0, 0));
        dir_tab.push_back(mk_typed(mk(CMD_WRITE, CH_STAR, 3'd2, 4'd0, 5'd0), EV_WAIT, 0, 0));
        dir_tab.push_back(mk_typed(mk(CMD_LEN, 8'h00, 3'd2, 4'd0, 5'd1), EV_WAIT, 0, 0));
        dir_tab.push_back(mk_typed(mk(CMD_WRITE, 8'hff, 3'd7, 4'd15, 5'd0), EV_WAIT, 0, 0));
        // partial, then escaped dot and wildcard complete the match
        dir_tab.push_back(mk(CMD_CHAR, 8'h61, 3'd0, 4'd0, 5'd0));
        dir_tab.push_back(mk(CMD_CHAR, CH_DOT, 3'd0, 4'd0, 5'd0));
        dir_tab.push_back(mk(CMD_CHAR, 8'hf8, 3'd0, 4'd0, 5'd0));
        // slot 0 misses; star slot 2 matches first, length 0 as empty slots match
        dir_tab.push_back(mk(CMD_CHAR, 8'h71, 3'd0, 4'd0, 5'd0));
        dir_tab.push_back(mk(CMD_SCAN, 8'h00, 3'd0, 4'd0, 5'd0));
        dir_tab.push_back(mk_typed(mk(CMD_TIMEOUT, 8'h00, 3'd0, 4'd0, 5'd0), EV_TIMEOUT, 1, 0));
        foreach (dir_tab[i])
            send(dir_tab[i]);
        drain();

        // Random phases, each with its own count and idling mix
        for (int ph = 0; ph < 8; ph++) begin
            write_count(counts[ph]);
            gap_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 50);
            stall_pct = (ph % 4 == 1) ? 0 : $urandom_range(10, 50);
            for (int k = 0; k < MAX_TRANSITIONS; k++)
                if ($urandom_range(0, 1))
                    program_slot(k);
            if (ph == 2) begin
                // receiver holds off long enough for the input to back up
                hold_cycles = 400;
                for (int i = 0; i < 12; i++)
                    send(mk(CMD_CHAR, pick_char(), '0, '0, '0));
            end
            for (int i = 0; i < 55; i++) begin
                random_item();
                if (i == 27) begin
                    // sender waits until everything outstanding has come back
                    in_valid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (fail_cnt == 0)
            $display("** expect_pattern_matcher: PASSED **");
        else
            $display("** expect_pattern_matcher: FAILED **");
        $finish;
    end

    // Hard stop in case the block hangs
    initial begin
        #1s;
        $display("** expect_pattern_matcher: FAILED **");
        $finish;
    end

endmodule
